// ----- rtl/pfsp_pkg.sv -----
// ----------------------------------------------------------------------------
// pfsp_pkg
// Shared types and character constants for the pixel-format name parser.
// ----------------------------------------------------------------------------
package pfsp_pkg;

  // Character codes (lower case after folding)
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_UA  = 8'h41;  // 'A'
  localparam logic [7:0] CH_UZ  = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_G   = 8'h67;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_L   = 8'h6C;
  localparam logic [7:0] CH_D   = 8'h64;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_1   = 8'h31;
  localparam logic [7:0] CH_2   = 8'h32;
  localparam logic [7:0] CH_3   = 8'h33;
  localparam logic [7:0] CH_6   = 8'h36;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_LETTER = 3'd1;
  localparam logic [2:0] ST_NO_DIGIT  = 3'd2;
  localparam logic [2:0] ST_TRAILING  = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;

  // Token queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    PH_LETTERS = 2'd0,
    PH_SIZES   = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    PEND_NONE  = 2'd0,
    PEND_ONE   = 2'd1,
    PEND_THREE = 2'd2
  } pend_t;

  // Classified character
  typedef struct packed {
    logic [7:0] c;      // folded character
    logic       term;   // name terminator
    logic       chan;   // channel letter
    logic       digit;  // decimal digit
  } tok_t;

endpackage

// ----- rtl/pfsp_front.sv -----
// ----------------------------------------------------------------------------
// pfsp_front
// Folds one character to lower case and classifies it into a token.
// ----------------------------------------------------------------------------
module pfsp_front (
  input  logic [7:0]     ch,
  output pfsp_pkg::tok_t tok
);
  import pfsp_pkg::*;

  logic [7:0] folded;

  // fold ASCII upper case only; other bytes pass untouched
  always_comb begin
    if (ch >= CH_UA && ch <= CH_UZ) begin
      folded = ch + CASE_OFFSET;
    end else begin
      folded = ch;
    end
  end

  always_comb begin
    tok.c     = folded;
    tok.term  = (folded == CH_NUL);
    tok.chan  = (folded == CH_R) || (folded == CH_G) || (folded == CH_B) ||
                (folded == CH_A) || (folded == CH_L) || (folded == CH_D);
    tok.digit = (folded >= CH_0) && (folded <= CH_9);
  end

endmodule

// ----- rtl/pfsp_queue.sv -----
// ----------------------------------------------------------------------------
// pfsp_queue
// Short token queue that decouples the classifier from the parser.
// ----------------------------------------------------------------------------
module pfsp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  pfsp_pkg::tok_t wr_tok,
  output logic           full,
  input  logic           rd_en,
  output pfsp_pkg::tok_t rd_tok,
  output logic           avail
);
  import pfsp_pkg::*;

  tok_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;

  assign full   = (count == (Q_AW+1)'(Q_DEPTH));
  assign avail  = (count != '0);
  assign rd_tok = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/pfsp_back.sv -----
// ----------------------------------------------------------------------------
// pfsp_back
// Parses the token stream and holds the finished code in an output register.
// ----------------------------------------------------------------------------
module pfsp_back #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           tok_avail,
  input  pfsp_pkg::tok_t tok,
  output logic           tok_take,
  output logic           res_valid,
  input  logic           res_pop,
  output logic [63:0]    res_type,
  output logic [2:0]     res_status
);
  import pfsp_pkg::*;

  localparam logic [2:0] MaxCh = 3'(MAX_CHANNELS);

  phase_t      phase, phase_next;
  pend_t       pend, pend_next;
  logic [2:0]  letter_count, letter_count_next;
  logic [2:0]  size_count, size_count_next;
  logic [63:0] code_acc, code_acc_next;
  logic [2:0]  first_error, first_error_next;
  logic [63:0] emit_type;
  logic [2:0]  emit_status;
  logic        size_step;
  logic        used;
  logic        emit;

  // a terminator needs a free output slot; other words always flow
  assign tok_take = tok_avail && (!tok.term || !res_valid || res_pop);
  assign emit     = tok_take && tok.term;

  always_comb begin
    phase_next        = phase;
    pend_next         = pend;
    letter_count_next = letter_count;
    size_count_next   = size_count;
    code_acc_next     = code_acc;
    first_error_next  = first_error;
    size_step         = 1'b0;
    used              = 1'b0;
    emit_type         = '0;
    emit_status       = ST_OK;

    if (tok_take) begin
      case (phase)
        PH_LETTERS: begin
          if (!tok.term && tok.chan && letter_count < MaxCh) begin
            code_acc_next[{1'b0, letter_count[1:0], 3'b000} +: 8] = tok.c;
            letter_count_next = letter_count + 1'b1;
          end else if (letter_count == '0) begin
            if (first_error_next == ST_OK) first_error_next = ST_NO_LETTER;
            phase_next = PH_ERROR;
          end else if (tok.digit) begin
            phase_next = PH_SIZES;
            size_step  = 1'b1;
          end else begin
            if (first_error_next == ST_OK) first_error_next = ST_NO_DIGIT;
            phase_next = PH_ERROR;
          end
        end
        PH_SIZES: begin
          // resolve a held digit against this character
          case (pend)
            PEND_ONE: begin
              if (tok.c == CH_0 || tok.c == CH_1 || tok.c == CH_2 || tok.c == CH_6) begin
                code_acc_next[{1'b1, size_count_next[1:0], 3'b000} +: 8] =
                  8'd10 + {4'b0000, tok.c[3:0]};
                used = 1'b1;
              end else begin
                code_acc_next[{1'b1, size_count_next[1:0], 3'b000} +: 8] = 8'd1;
              end
              size_count_next = size_count_next + 1'b1;
            end
            PEND_THREE: begin
              if (tok.c == CH_2) begin
                code_acc_next[{1'b1, size_count_next[1:0], 3'b000} +: 8] = 8'd32;
                used = 1'b1;
              end else begin
                code_acc_next[{1'b1, size_count_next[1:0], 3'b000} +: 8] = 8'd3;
              end
              size_count_next = size_count_next + 1'b1;
            end
            default: begin
            end
          endcase
          pend_next = PEND_NONE;
          size_step = !used && !tok.term;
        end
        default: begin
        end
      endcase

      // one size character with nothing held
      if (size_step) begin
        if (size_count_next >= MaxCh || !tok.digit) begin
          if (first_error_next == ST_OK) first_error_next = ST_TRAILING;
          phase_next = PH_ERROR;
        end else if (tok.c == CH_1) begin
          pend_next = PEND_ONE;
        end else if (tok.c == CH_3) begin
          pend_next = PEND_THREE;
        end else begin
          code_acc_next[{1'b1, size_count_next[1:0], 3'b000} +: 8] =
            {4'b0000, tok.c[3:0]};
          size_count_next = size_count_next + 1'b1;
        end
      end

      // end of name: report, then start over
      if (tok.term) begin
        if (first_error_next == ST_OK && letter_count_next != size_count_next) begin
          first_error_next = ST_MISMATCH;
        end
        emit_status       = first_error_next;
        emit_type         = (first_error_next == ST_OK) ? code_acc_next : '0;
        phase_next        = PH_LETTERS;
        pend_next         = PEND_NONE;
        letter_count_next = '0;
        size_count_next   = '0;
        code_acc_next     = '0;
        first_error_next  = ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LETTERS;
      pend         <= PEND_NONE;
      letter_count <= '0;
      size_count   <= '0;
      code_acc     <= '0;
      first_error  <= ST_OK;
      res_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      pend         <= pend_next;
      letter_count <= letter_count_next;
      size_count   <= size_count_next;
      code_acc     <= code_acc_next;
      first_error  <= first_error_next;
      if (emit) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_type   <= emit_type;
      res_status <= emit_status;
    end
  end

  a_letters_bound: assert property (@(posedge clk) disable iff (rst)
    letter_count <= MaxCh) else $error("letter count past channel limit");

  a_sizes_bound: assert property (@(posedge clk) disable iff (rst)
    size_count <= MaxCh) else $error("size count past channel limit");

  a_pend_in_sizes: assert property (@(posedge clk) disable iff (rst)
    pend != PEND_NONE |-> phase == PH_SIZES) else $error("held digit outside sizes");

  a_error_recorded: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ERROR |-> first_error != ST_OK) else $error("error phase without code");

  a_error_zero_code: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != ST_OK |-> res_type == '0)
    else $error("nonzero code on error");

  a_emit_resets: assert property (@(posedge clk) disable iff (rst)
    emit |=> phase == PH_LETTERS && letter_count == '0 && code_acc == '0)
    else $error("state not cleared after terminator");

endmodule

// ----- rtl/pixel_format_string_parser.sv -----
// ----------------------------------------------------------------------------
// pixel_format_string_parser
// Parses a pixel-format name one character per word into a 64-bit code.
// ----------------------------------------------------------------------------
// Throughput: one character word per cycle, sustained, including terminators
//   as long as results are popped as they appear.
// Result: a terminator shows its result (empty low) once the parser takes
//   it from the token queue and loads the output register. A result left
//   unpopped holds the next terminator.
// Reset: synchronous rst empties the queue and output and returns the parser
//   to reading channel letters with a zero code and no error.
module pixel_format_string_parser #(
  parameter int MAX_CHANNELS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] pixel_type,
  output logic [2:0]  status
);
  import pfsp_pkg::*;

  tok_t in_tok;
  tok_t q_tok;
  logic q_avail;
  logic q_take;
  logic res_valid;

  // Front: fold case and classify the incoming character.
  pfsp_front u_front (
    .ch  (ch),
    .tok (in_tok)
  );

  // Queue: absorb words while the parser waits on a full output.
  pfsp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push && !full),
    .wr_tok (in_tok),
    .full   (full),
    .rd_en  (q_take),
    .rd_tok (q_tok),
    .avail  (q_avail)
  );

  // Back: run the name grammar and hold the finished code until popped.
  pfsp_back #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_avail  (q_avail),
    .tok        (q_tok),
    .tok_take   (q_take),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res_type   (pixel_type),
    .res_status (status)
  );

  assign empty = !res_valid;

endmodule

// ----- test/pfsp_name_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfsp_name_checker
// Watches the character and result queues of the pixel-format name parser,
// decodes every accepted character itself and compares each popped result
// with the oldest decoded name, reporting a running mismatch count.
// ----------------------------------------------------------------------------
module pfsp_name_checker #(
  parameter int MAX_CH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  ch,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] pixel_type,
  input  logic [2:0]  status,
  output int          mismatches,
  output int          outstanding
);
  import pfsp_pkg::*;

  typedef struct packed {
    logic [63:0] code;
    logic [2:0]  st;
  } name_result_t;

  // Decoder state
  phase_t      ph;
  pend_t       held;
  logic [2:0]  n_letters;
  logic [2:0]  n_sizes;
  logic [63:0] code_acc;
  logic [2:0]  err;

  name_result_t decoded_q[$];

  task automatic clear_name();
    ph        = PH_LETTERS;
    held      = PEND_NONE;
    n_letters = '0;
    n_sizes   = '0;
    code_acc  = '0;
    err       = ST_OK;
  endtask

  task automatic flag_error(input logic [2:0] e);
    if (err == ST_OK) err = e;
    ph = PH_ERROR;
  endtask

  task automatic put_size(input logic [7:0] v);
    code_acc = code_acc | ({56'd0, v} << (8 * (4 + n_sizes[1:0])));
    n_sizes  = n_sizes + 1'b1;
  endtask

  // One non-terminator while reading sizes, with no digit held
  task automatic size_char(input logic [7:0] c);
    if (n_sizes >= MAX_CH) flag_error(ST_TRAILING);
    else if (!(c >= CH_0 && c <= CH_9)) flag_error(ST_TRAILING);
    else if (c == CH_1) held = PEND_ONE;
    else if (c == CH_3) held = PEND_THREE;
    else put_size(c - CH_0);
  endtask

  task automatic decode_char(input logic [7:0] raw, output bit done,
                             output name_result_t res);
    logic [7:0] c;
    bit         used;
    c    = raw;
    used = 1'b0;
    res  = '0;
    if (c >= CH_UA && c <= CH_UZ) c = c + CASE_OFFSET;
    case (ph)
      PH_LETTERS: begin
        if (c != CH_NUL && n_letters < MAX_CH &&
            (c == CH_R || c == CH_G || c == CH_B ||
             c == CH_A || c == CH_L || c == CH_D)) begin
          code_acc  = code_acc | ({56'd0, c} << (8 * n_letters[1:0]));
          n_letters = n_letters + 1'b1;
        end else if (n_letters == 0) begin
          flag_error(ST_NO_LETTER);
        end else if (c >= CH_0 && c <= CH_9) begin
          ph = PH_SIZES;
          size_char(c);
        end else begin
          flag_error(ST_NO_DIGIT);
        end
      end
      PH_SIZES: begin
        if (held == PEND_ONE) begin
          if (c == CH_0 || c == CH_1 || c == CH_2 || c == CH_6) begin
            put_size(8'd10 + (c - CH_0));
            used = 1'b1;
          end else begin
            put_size(8'd1);
          end
        end else if (held == PEND_THREE) begin
          if (c == CH_2) begin
            put_size(8'd32);
            used = 1'b1;
          end else begin
            put_size(8'd3);
          end
        end
        held = PEND_NONE;
        if (!used && c != CH_NUL) size_char(c);
      end
      default: ;
    endcase
    done = (c == CH_NUL);
    if (done) begin
      if (err == ST_OK && n_letters != n_sizes) err = ST_MISMATCH;
      res.code = (err == ST_OK) ? code_acc : 64'd0;
      res.st   = err;
      clear_name();
    end
  endtask

  task automatic note_miss(input string what, input logic [63:0] want,
                           input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin : watch_queues
    bit           done;
    name_result_t res;
    name_result_t want;
    if (rst) begin
      clear_name();
      decoded_q.delete();
      mismatches = 0;
    end else begin
      if (push && !full) begin
        decode_char(ch, done, res);
        if (done) decoded_q.insert(decoded_q.size(), res);
      end
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          note_miss("unexpected result word", 64'd0, pixel_type);
        end else begin
          want = decoded_q.pop_front();
          if (pixel_type !== want.code) note_miss("pixel_type", want.code, pixel_type);
          if (status !== want.st) note_miss("status", {61'd0, want.st}, {61'd0, status});
        end
      end
    end
    outstanding <= decoded_q.size();
  end

endmodule

// ----- test/pixel_format_string_parser_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_format_string_parser_tb
// Feeds pixel-format names to the parser one character word at a time:
// a few hand-picked names first, then random names that are mostly well
// formed, some corrupted and some pure noise. A checker beside the parser
// decodes the same words and compares every result word.
// ----------------------------------------------------------------------------
module pixel_format_string_parser_tb;
  import pfsp_pkg::*;

  localparam int MAX_CH      = 4;
  localparam int N_WORDS     = 700;   // stop starting new names past this
  localparam int CALM_AT     = 600;   // no idling on either side from here on
  localparam int HOLD_AT     = 250;   // receiver hold-off starts after this
  localparam int HOLD_CYCLES = 80;
  localparam int STALL_LIMIT = 2000;  // cycles without any handshake

  logic        clk  = 1'b0;
  logic        rst  = 1'b1;
  logic        push = 1'b0;
  logic [7:0]  ch   = CH_NUL;
  logic        pop  = 1'b0;
  logic        full;
  logic        empty;
  logic [63:0] pixel_type;
  logic [2:0]  status;

  logic        calm = 1'b0;
  int          mismatches;
  int          outstanding;
  int          words_in = 0;
  int          stall_cycles = 0;

  // Receiver state
  int          hold_left = 0;
  bit          held_once = 1'b0;
  int          pop_gap = 0;
  int          rx_cycle = 0;
  bit          rx_idle_mode = 1'b1;

  logic [7:0]  name_buf[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pixel_format_string_parser #(
    .MAX_CHANNELS(MAX_CH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .ch        (ch),
    .empty     (empty),
    .pop       (pop),
    .pixel_type(pixel_type),
    .status    (status)
  );

  pfsp_name_checker #(
    .MAX_CH(MAX_CH)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .ch         (ch),
    .empty      (empty),
    .pop        (pop),
    .pixel_type (pixel_type),
    .status     (status),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Count accepted character words; the receiver keys its hold-off on this.
  always @(posedge clk) begin
    if (!rst && push && !full) words_in <= words_in + 1;
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: pop most cycles, drop pop for random bursts while in an
  // idling stretch, and once hold pop low long enough for the parser to
  // back up into its input.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_idle_mode <= ($urandom_range(0, 2) != 0);
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!held_once && words_in >= HOLD_AT) begin
      held_once <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      pop       <= 1'b0;
    end else if (pop_gap != 0) begin
      pop     <= 1'b0;
      pop_gap <= pop_gap - 1;
    end else if (!calm && rx_idle_mode && $urandom_range(0, 4) == 0) begin
      pop     <= 1'b0;
      pop_gap <= $urandom_range(0, 3);
    end else begin
      pop <= 1'b1;
    end
  end

  // Offer one character word, optionally after an idle burst, and hold it
  // until the parser takes it. Returns in the step of the accepting edge.
  task automatic send_word(input logic [7:0] c, input bit may_idle);
    int gap;
    if (may_idle && !calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    ch   <= c;
    do @(posedge clk); while (full);
  endtask

  // Send a literal name followed by its terminator.
  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_word(s[i], 1'b1);
    send_word(CH_NUL, 1'b1);
  endtask

  // Append one character to the end of name_buf.
  task automatic buf_add(input logic [7:0] c);
    name_buf.insert(name_buf.size(), c);
  endtask

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0: c = CH_R;
      1: c = CH_G;
      2: c = CH_B;
      3: c = CH_A;
      4: c = CH_L;
      default: c = CH_D;
    endcase
    // Fold half of them up to upper case.
    if ($urandom_range(0, 1) == 1) c = c - CASE_OFFSET;
    return c;
  endfunction

  // Append one size token: a single digit or one of the digit pairs.
  task automatic add_size_token();
    int k;
    k = $urandom_range(0, 14);
    if (k < 10) begin
      buf_add(CH_0 + 8'(k));
    end else begin
      buf_add((k == 14) ? CH_3 : CH_1);
      case (k)
        10: buf_add(CH_0);
        11: buf_add(CH_1);
        12: buf_add(CH_2);
        13: buf_add(CH_6);
        default: buf_add(CH_2);
      endcase
    end
  endtask

  // Build one random name into name_buf, terminator included. Most names
  // are letters then sizes so that the size phase gets real exercise;
  // some get a stray byte inserted or overwritten, the rest are noise.
  task automatic build_name();
    int         kind;
    int         n_let;
    int         n_tok;
    int         pos;
    logic [7:0] junk;
    name_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      n_let = $urandom_range(1, MAX_CH);
      if ($urandom_range(0, 9) == 0) n_let = MAX_CH + 1;
      n_tok = (n_let > MAX_CH) ? MAX_CH : n_let;
      if ($urandom_range(0, 6) == 0) n_tok = $urandom_range(0, MAX_CH + 1);
      repeat (n_let) buf_add(pick_letter());
      repeat (n_tok) add_size_token();
      if (kind >= 65) begin
        junk = 8'($urandom_range(1, 255));
        pos  = $urandom_range(0, name_buf.size());
        if ($urandom_range(0, 1) == 1) name_buf.insert(pos, junk);
        else if (pos < name_buf.size()) name_buf[pos] = junk;
      end
    end else begin
      repeat ($urandom_range(0, 8)) buf_add(8'($urandom_range(1, 255)));
    end
    buf_add(CH_NUL);
  endtask

  initial begin : stimulus
    bit quiet;
    int i;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Hand-picked names, one per status plus the tricky corners.
    send_text("");          // empty name
    send_text("rgbad");     // a fifth letter where a digit belongs
    send_text("L");         // letters then terminator
    send_text("a112");      // three digits: 11 then 2, so counts differ
    send_text("Rgb3132");   // held digits that do not pair: 3, 1, 32
    send_text("d8x");       // symbol among the sizes
    send_text("\377rgb");   // non-ASCII first, the first error sticks

    // Random names until enough words have gone in.
    while (words_in < N_WORDS) begin
      build_name();
      quiet = ($urandom_range(0, 3) == 0);
      for (i = 0; i < name_buf.size(); i++) send_word(name_buf[i], !quiet);
      if (words_in >= CALM_AT) calm <= 1'b1;
    end
    push <= 1'b0;

    // Drain: let the checker see the last word, wait for every decoded
    // name, then give stray results a chance.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
